### rtl/averaging_capture_buffer_top_macros.svh
// Assertion macros for the averaging capture buffer.
`ifndef AVERAGING_CAPTURE_BUFFER_TOP_MACROS_SVH
`define AVERAGING_CAPTURE_BUFFER_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define ACB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define ACB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/acb_pkg.sv
// Shared types and constants for the averaging capture buffer.
package acb_pkg;

  localparam int CH_W       = 3;
  localparam int DATA_W     = 32;
  localparam int RIDX_W     = 11;
  localparam int PT_W       = 12;
  localparam int NSIG_W     = 4;
  localparam int NAVG_W     = 16;
  localparam int SUM_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [NSIG_W-1:0] RST_NUM_SIGNALS = 4'd8;
  localparam logic [PT_W-1:0]   RST_NUM_POINTS  = 12'd2048;
  localparam logic [NAVG_W-1:0] RST_NUM_AVERAGE = 16'd1;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_START,
    CMD_STOP,
    CMD_READ
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SIGNALS,
    CFG_NUM_POINTS,
    CFG_NUM_AVERAGE,
    CFG_CIRCULAR_MODE
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_STORE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] sample_value;
    logic                     end_of_point;
    logic [RIDX_W-1:0]        read_index;
  } acb_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic                     read_valid;
    logic                     acquiring;
    logic [PT_W-1:0]          write_point;
    logic                     point_stored;
  } acb_out_t;

  typedef struct packed {
    logic in_take;
    logic exec;
    logic div_load;
    logic div_store;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic store_due;
    logic div_busy;
    logic last_ch;
    logic out_busy;
  } stat_t;

endpackage

### rtl/acb_div.sv
// Restoring divider: unsigned sum magnitude by average count, one bit per cycle.
module acb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [acb_pkg::SUM_W-1:0]   dividend,
  input  logic [acb_pkg::NAVG_W-1:0]  divisor,
  output logic                        busy,
  output logic [acb_pkg::SUM_W-1:0]   quotient
);
  import acb_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [NAVG_W:0]    rem;
  logic [NAVG_W:0]    rem_next;
  logic [NAVG_W:0]    shifted;
  logic [NAVG_W-1:0]  dsr;
  logic [SUM_W-1:0]   quo;
  logic [SUM_W-1:0]   quo_next;
  logic [CNT_W-1:0]   cnt;

  always_comb begin
    shifted = {rem[NAVG_W-1:0], quo[SUM_W-1]};
    if (shifted >= {1'b0, dsr}) begin
      rem_next = shifted - {1'b0, dsr};
      quo_next = {quo[SUM_W-2:0], 1'b1};
    end else begin
      rem_next = shifted;
      quo_next = {quo[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

### rtl/acb_ctrl.sv
// Controller state machine sequencing item execution, division and result hand-off.
module acb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  acb_pkg::stat_t  stat,
  output acb_pkg::ctrl_t  ctrl
);
  import acb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = stat.store_due ? ST_DIV_LOAD : ST_FINISH;
      end
      ST_DIV_LOAD: begin
        state_next = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (!stat.div_busy) state_next = ST_DIV_STORE;
      end
      ST_DIV_STORE: begin
        state_next = stat.last_ch ? ST_FINISH : ST_DIV_LOAD;
      end
      ST_FINISH: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    ctrl.in_take   = (state == ST_IDLE) && in_valid;
    ctrl.exec      = (state == ST_EXEC);
    ctrl.div_load  = (state == ST_DIV_LOAD);
    ctrl.div_store = (state == ST_DIV_STORE);
    ctrl.out_load  = (state == ST_FINISH) && !stat.out_busy;
  end

endmodule

### rtl/acb_dpath.sv
// Datapath: configuration, channel sums, capture memory, divider and result register.
module acb_dpath #(
  parameter int MAX_CHANNELS = 8,
  parameter int BUFFER_DEPTH = 2048,
  parameter int SAMPLE_BITS  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [acb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  acb_pkg::acb_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output acb_pkg::acb_out_t                out_data,
  input  acb_pkg::ctrl_t                   ctrl,
  output acb_pkg::stat_t                   stat
);
  import acb_pkg::*;

  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NSW   = $clog2(MAX_CHANNELS + 1);
  localparam int DEPTH = MAX_CHANNELS * BUFFER_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [SUM_W-1:0] Q_HI = SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] Q_LO = ~Q_HI;

  logic [NSIG_W-1:0] num_signals;
  logic [PT_W-1:0]   num_points;
  logic [NAVG_W-1:0] num_average;
  logic              circular_mode;

  logic [SUM_W-1:0]  sums [MAX_CHANNELS];
  logic [NAVG_W-1:0] points_summed;
  logic [PT_W-1:0]   next_write;
  logic              running;
  logic              wrapped;

  acb_in_t           item;
  logic [CW-1:0]     dch;
  logic              neg;
  logic              stored_f;
  logic              rd_ok;
  logic              rd_hit;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;

  logic [NSW-1:0]    ns_eff;
  logic [PT_W-1:0]   np_eff;
  logic [NAVG_W-1:0] need;
  logic              ch_used;
  logic [CW-1:0]     ch_idx;
  logic [CW-1:0]     sum_idx;
  logic [SUM_W-1:0]  sum_sel;
  logic [SUM_W-1:0]  sample_ext;
  logic [SUM_W-1:0]  dividend;
  logic              div_busy;
  logic [SUM_W-1:0]  quo;
  logic [SUM_W-1:0]  q_signed;
  logic [SUM_W-1:0]  q_sat;
  logic [PT_W-1:0]   nw_inc;
  logic [PT_W:0]     rsum;
  logic [PT_W-1:0]   pos_c;
  logic [PT_W-1:0]   rd_pos;
  logic              rd_valid_c;
  logic              rd_hit_c;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              mem_re;

  always_comb begin
    if (num_signals == '0) begin
      ns_eff = NSW'(1);
    end else if (int'(num_signals) > MAX_CHANNELS) begin
      ns_eff = NSW'(MAX_CHANNELS);
    end else begin
      ns_eff = NSW'(num_signals);
    end
    if (num_points == '0) begin
      np_eff = PT_W'(1);
    end else if (int'(num_points) > BUFFER_DEPTH) begin
      np_eff = PT_W'(BUFFER_DEPTH);
    end else begin
      np_eff = num_points;
    end
  end

  assign need       = (num_average == '0) ? NAVG_W'(1) : num_average;
  assign ch_idx     = CW'(item.channel);
  assign ch_used    = 8'(item.channel) < 8'(ns_eff);
  assign sum_idx    = ctrl.div_load ? dch : ch_idx;
  assign sum_sel    = sums[sum_idx];
  assign sample_ext = {{(SUM_W - SAMPLE_BITS){item.sample_value[SAMPLE_BITS-1]}},
                       item.sample_value[SAMPLE_BITS-1:0]};
  assign dividend   = sum_sel[SUM_W-1] ? (SUM_W'(0) - sum_sel) : sum_sel;
  assign nw_inc     = next_write + PT_W'(1);

  assign stat.store_due = (item.cmd == CMD_SAMPLE) && running && item.end_of_point &&
                          ((17'(points_summed) + 17'd1) >= 17'(need));
  assign stat.div_busy  = div_busy;
  assign stat.last_ch   = (8'(dch) + 8'd1) == 8'(ns_eff);
  assign stat.out_busy  = out_valid && !out_ready;

  acb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_load),
    .dividend (dividend),
    .divisor  (need),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    q_signed = neg ? (SUM_W'(0) - quo) : quo;
    if ($signed(q_signed) > $signed(Q_HI)) begin
      q_sat = Q_HI;
    end else if ($signed(q_signed) < $signed(Q_LO)) begin
      q_sat = Q_LO;
    end else begin
      q_sat = q_signed;
    end
  end

  always_comb begin
    rsum  = {1'b0, next_write} + (PT_W + 1)'(item.read_index);
    pos_c = (rsum >= {1'b0, np_eff}) ? PT_W'(rsum - {1'b0, np_eff}) : PT_W'(rsum);
    if (circular_mode) begin
      rd_valid_c = PT_W'(item.read_index) < np_eff;
      rd_pos     = pos_c;
      rd_hit_c   = wrapped || (pos_c < next_write);
    end else begin
      rd_valid_c = PT_W'(item.read_index) < next_write;
      rd_pos     = PT_W'(item.read_index);
      rd_hit_c   = 1'b1;
    end
    rd_valid_c = rd_valid_c && ch_used && (item.cmd == CMD_READ);
  end

  assign rd_addr = AW'(int'(ch_idx) * BUFFER_DEPTH) + AW'(rd_pos);
  assign wr_addr = AW'(int'(dch) * BUFFER_DEPTH) + AW'(next_write);
  assign mem_re  = ctrl.exec && rd_valid_c && rd_hit_c;

  always_ff @(posedge clk) begin
    if (ctrl.div_store) begin
      mem[wr_addr] <= q_sat[DATA_W-1:0];
    end
    if (mem_re) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_signals   <= RST_NUM_SIGNALS;
      num_points    <= RST_NUM_POINTS;
      num_average   <= RST_NUM_AVERAGE;
      circular_mode <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sums[i] <= '0;
      end
      points_summed <= '0;
      next_write    <= '0;
      running       <= 1'b0;
      wrapped       <= 1'b0;
      dch           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_NUM_SIGNALS: begin
            num_signals <= cfg_data[NSIG_W-1:0];
            next_write  <= '0;
            wrapped     <= 1'b0;
          end
          CFG_NUM_POINTS: begin
            num_points <= cfg_data[PT_W-1:0];
            next_write <= '0;
            wrapped    <= 1'b0;
          end
          CFG_NUM_AVERAGE: begin
            num_average   <= cfg_data[NAVG_W-1:0];
            points_summed <= '0;
          end
          CFG_CIRCULAR_MODE: begin
            circular_mode <= cfg_data[0];
            next_write    <= '0;
            wrapped       <= 1'b0;
          end
        endcase
      end

      if (ctrl.exec) begin
        dch <= '0;
        unique case (item.cmd)
          CMD_SAMPLE: begin
            if (running) begin
              if (ch_used) begin
                sums[ch_idx] <= sum_sel + sample_ext;
              end
              if (item.end_of_point && !stat.store_due) begin
                points_summed <= points_summed + NAVG_W'(1);
              end
            end
          end
          CMD_START: begin
            next_write <= '0;
            wrapped    <= 1'b0;
            running    <= 1'b1;
          end
          CMD_STOP: begin
            running <= 1'b0;
          end
          CMD_READ: begin
          end
        endcase
      end

      if (ctrl.div_store) begin
        sums[dch] <= '0;
        if (stat.last_ch) begin
          points_summed <= '0;
          if (nw_inc >= np_eff) begin
            if (circular_mode) begin
              next_write <= '0;
              wrapped    <= 1'b1;
            end else begin
              next_write <= nw_inc;
              running    <= 1'b0;
            end
          end else begin
            next_write <= nw_inc;
          end
        end else begin
          dch <= dch + CW'(1);
        end
      end

      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.in_take) begin
      item <= in_data;
    end
    if (ctrl.exec) begin
      stored_f <= 1'b0;
      rd_ok    <= rd_valid_c;
      rd_hit   <= rd_hit_c;
    end
    if (ctrl.div_load) begin
      neg <= sum_sel[SUM_W-1];
    end
    if (ctrl.div_store && stat.last_ch) begin
      stored_f <= 1'b1;
    end
    if (ctrl.out_load) begin
      out_data.read_data    <= (rd_ok && rd_hit) ? $signed(mem_q) : '0;
      out_data.read_valid   <= rd_ok;
      out_data.acquiring    <= running;
      out_data.write_point  <= next_write;
      out_data.point_stored <= stored_f;
    end
  end

endmodule

### rtl/averaging_capture_buffer_top.sv
// Multi-channel boxcar-decimating capture buffer, top level.
// Takes one item at a time. For a start, stop, read or a sample that does not close an
// averaging group, the item goes through the execute and finish states, and its result
// beat is then loaded into the output register. A sample that completes a group of
// num_average points runs the shared 48-step restoring divider (one quotient bit per
// cycle) once per channel in use, each time through a load state, a run state held
// until the divider drops busy, and a store state. The result sits in an output
// register, and the next item is taken while it waits.
// The capture memory is never cleared: the write point and a wrap flag mark which
// entries hold data, and entries not yet written read as zero, so no clearing pass
// follows reset or start.
`include "averaging_capture_buffer_top_macros.svh"

module averaging_capture_buffer_top #(
  parameter int MAX_CHANNELS = 8,
  parameter int BUFFER_DEPTH = 2048,
  parameter int SAMPLE_BITS  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [acb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  acb_pkg::acb_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output acb_pkg::acb_out_t                out_data
);
  import acb_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  acb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  acb_dpath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  `ACB_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second beat taken mid-item")
  `ACB_ASSERT_NEXT(a_div_start, ctrl.div_load, stat.div_busy, "divider did not start")
  `ACB_ASSERT_NOW(a_div_done, ctrl.div_store, !stat.div_busy, "quotient stored while busy")
  `ACB_ASSERT_NOW(a_result_kind, out_valid, !(out_data.read_valid && out_data.point_stored), "read and store in one beat")

endmodule

### test/averaging_capture_buffer_top_tb.sv
// Self-checking testbench for the averaging capture buffer with its own predictor.
`timescale 1ns / 100ps

module averaging_capture_buffer_top_tb;
  import acb_pkg::*;

  localparam int MAX_CH = 8;
  localparam int DEPTH = 2048;
  localparam longint SAT_HI = 2147483647;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam int RANDOM_ITEMS = 600;
  localparam int PHASES = 6;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  acb_in_t in_data;
  logic out_valid;
  logic out_ready;
  acb_out_t out_data;

  averaging_capture_buffer_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // predictor state
  logic [3:0] nsig;
  logic [11:0] npts;
  logic [15:0] navg;
  logic circ;
  logic [47:0] acc_sum [MAX_CH];
  logic [15:0] acc_count;
  logic [11:0] wr_ptr;
  logic capturing;
  logic signed [31:0] capture_mem [MAX_CH][DEPTH];

  acb_out_t expected_q [$];
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int points_predicted = 0;
  int valid_reads = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    out_ready <= sink_idle_en ? ($urandom_range(99) >= 32) : 1'b1;
  end

  function automatic int unsigned used_channels();
    if (nsig == 0) return 1;
    if (nsig > MAX_CH) return MAX_CH;
    return nsig;
  endfunction

  function automatic int unsigned used_points();
    if (npts == 0) return 1;
    if (npts > DEPTH) return DEPTH;
    return npts;
  endfunction

  function automatic void clear_capture();
    for (int c = 0; c < MAX_CH; c++) begin
      for (int p = 0; p < DEPTH; p++) capture_mem[c][p] = '0;
    end
    wr_ptr = '0;
  endfunction

  function automatic void reset_predictor();
    nsig = RST_NUM_SIGNALS;
    npts = RST_NUM_POINTS;
    navg = RST_NUM_AVERAGE;
    circ = 1'b0;
    for (int c = 0; c < MAX_CH; c++) acc_sum[c] = '0;
    acc_count = '0;
    capturing = 1'b0;
    clear_capture();
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [15:0] value);
    case (idx)
      CFG_NUM_SIGNALS: begin
        nsig = value[3:0];
        clear_capture();
      end
      CFG_NUM_POINTS: begin
        npts = value[11:0];
        clear_capture();
      end
      CFG_NUM_AVERAGE: begin
        navg = value;
        acc_count = '0;
      end
      CFG_CIRCULAR_MODE: begin
        circ = value[0];
        clear_capture();
      end
      default: ;
    endcase
  endfunction

  function automatic bit close_point(int unsigned ns, int unsigned np);
    int unsigned need;
    longint total;
    longint quot;
    acc_count = acc_count + 16'd1;
    need = (navg == 0) ? 1 : navg;
    if (acc_count < need) return 1'b0;
    for (int c = 0; c < ns; c++) begin
      total = {{16{acc_sum[c][47]}}, acc_sum[c]};
      quot = total / longint'(acc_count);
      if (quot > SAT_HI) quot = SAT_HI;
      if (quot < SAT_LO) quot = SAT_LO;
      if (wr_ptr < DEPTH) capture_mem[c][wr_ptr] = quot[31:0];
      acc_sum[c] = '0;
    end
    acc_count = '0;
    wr_ptr = wr_ptr + 12'd1;
    if (wr_ptr >= np) begin
      if (circ) wr_ptr = '0;
      else capturing = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic acb_out_t predict_item(acb_in_t it);
    acb_out_t res;
    int unsigned ns;
    int unsigned np;
    int unsigned pos;
    res = '0;
    pos = 0;
    ns = used_channels();
    np = used_points();
    case (it.cmd)
      CMD_SAMPLE: begin
        if (capturing) begin
          if (it.channel < ns) begin
            acc_sum[it.channel] = acc_sum[it.channel]
                                  + {{16{it.sample_value[31]}}, it.sample_value};
          end
          if (it.end_of_point) res.point_stored = close_point(ns, np);
        end
      end
      CMD_START: begin
        clear_capture();
        capturing = 1'b1;
      end
      CMD_STOP: capturing = 1'b0;
      default: begin
        if (it.channel < ns) begin
          if (circ) begin
            if (it.read_index < np) begin
              res.read_valid = 1'b1;
              pos = (wr_ptr + it.read_index) % np;
            end
          end else if (it.read_index < wr_ptr) begin
            res.read_valid = 1'b1;
            pos = it.read_index;
          end
          if (res.read_valid) res.read_data = capture_mem[it.channel][pos];
        end
      end
    endcase
    res.acquiring = capturing;
    res.write_point = wr_ptr;
    return res;
  endfunction

  function automatic acb_in_t build_item(cmd_t c, logic [2:0] ch, logic [31:0] v,
                                         logic eop, logic [10:0] ridx);
    acb_in_t it;
    it.cmd = c;
    it.channel = ch;
    it.sample_value = v;
    it.end_of_point = eop;
    it.read_index = ridx;
    return it;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < 40) begin
      $display("MISMATCH beat %0d %s: got %0d, want %0d at %0t",
               results_checked, what, got, want, $time);
    end
    error_count++;
  endtask

  always @(posedge clk) begin
    acb_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.read_valid !== want.read_valid)
          report_mismatch("read_valid", out_data.read_valid, want.read_valid);
        if (out_data.acquiring !== want.acquiring)
          report_mismatch("acquiring", out_data.acquiring, want.acquiring);
        if (out_data.write_point !== want.write_point)
          report_mismatch("write_point", out_data.write_point, want.write_point);
        if (out_data.point_stored !== want.point_stored)
          report_mismatch("point_stored", out_data.point_stored, want.point_stored);
      end
      results_checked++;
    end
  end

  task automatic send_item(input acb_in_t it);
    acb_out_t res;
    if (src_idle_en && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    res = predict_item(it);
    expected_q.push_back(res);
    items_sent++;
    if (res.point_stored) points_predicted++;
    if (res.read_valid) valid_reads++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, value);
  endtask

  task automatic test_idle_commands();
    send_item(build_item(CMD_READ, 3'd0, '0, 1'b0, 11'd0));
    send_item(build_item(CMD_SAMPLE, 3'd3, 32'd5, 1'b1, '0));
    send_item(build_item(CMD_STOP, '0, '0, 1'b0, '0));
    send_item(build_item(CMD_START, '0, '0, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd0, 32'h7fff_ffff, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd1, 32'h8000_0000, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd2, 32'h0, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd3, 32'hffff_ffff, 1'b0, '0));
    for (int c = 4; c < MAX_CH; c++)
      send_item(build_item(CMD_SAMPLE, 3'(c), $urandom, c == MAX_CH - 1, '0));
    send_item(build_item(CMD_READ, 3'd1, '0, 1'b0, 11'd0));
    send_item(build_item(CMD_READ, 3'd7, '0, 1'b0, 11'd2047));
    send_item(build_item(CMD_STOP, '0, '0, 1'b0, '0));
  endtask

  task automatic test_register_clamps();
    write_reg(CFG_NUM_SIGNALS, 16'd0);
    write_reg(CFG_NUM_POINTS, 16'd0);
    write_reg(CFG_NUM_AVERAGE, 16'd0);
    write_reg(CFG_CIRCULAR_MODE, 16'd1);
    send_item(build_item(CMD_START, '0, '0, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd0, -32'sd7, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd5, 32'd100, 1'b1, '0));
    send_item(build_item(CMD_READ, 3'd0, '0, 1'b0, 11'd0));
    send_item(build_item(CMD_READ, 3'd5, '0, 1'b0, 11'd0));
    send_item(build_item(CMD_READ, 3'd0, '0, 1'b0, 11'd1));
    write_reg(CFG_NUM_SIGNALS, 16'd15);
    write_reg(CFG_NUM_POINTS, 16'd1);
    write_reg(CFG_NUM_AVERAGE, 16'd2);
    write_reg(CFG_CIRCULAR_MODE, 16'd0);
    send_item(build_item(CMD_START, '0, '0, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd0, 32'h7fff_ffff, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd0, 32'h7fff_ffff, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd1, 32'h8000_0000, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd1, 32'h8000_0000, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd2, -32'sd3, 1'b1, '0));
    send_item(build_item(CMD_SAMPLE, 3'd7, 32'd0, 1'b1, '0));
    for (int c = 0; c < 3; c++) send_item(build_item(CMD_READ, 3'(c), '0, 1'b0, 11'd0));
    send_item(build_item(CMD_SAMPLE, 3'd0, 32'd9, 1'b1, '0));
  endtask

  task automatic test_quotient_saturation();
    write_reg(CFG_NUM_SIGNALS, 16'd2);
    write_reg(CFG_NUM_POINTS, 16'd5);
    write_reg(CFG_NUM_AVERAGE, 16'd1);
    send_item(build_item(CMD_START, '0, '0, 1'b0, '0));
    repeat (3) send_item(build_item(CMD_SAMPLE, 3'd0, 32'h7fff_ffff, 1'b0, '0));
    repeat (3) send_item(build_item(CMD_SAMPLE, 3'd1, 32'h8000_0000, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd1, -32'sd7, 1'b1, '0));
    write_reg(CFG_NUM_AVERAGE, 16'd3);
    repeat (2) send_item(build_item(CMD_SAMPLE, 3'd0, -32'sd6, 1'b0, '0));
    send_item(build_item(CMD_SAMPLE, 3'd1, 32'd7, 1'b1, '0));
    send_item(build_item(CMD_SAMPLE, 3'd0, 32'd1, 1'b1, '0));
    send_item(build_item(CMD_SAMPLE, 3'd1, 32'd1, 1'b1, '0));
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < 3; i++) send_item(build_item(CMD_READ, 3'(c), '0, 1'b0, 11'(i)));
    end
    send_item(build_item(CMD_STOP, '0, '0, 1'b0, '0));
  endtask

  task automatic test_deep_buffer();
    write_reg(CFG_NUM_SIGNALS, 16'd1);
    write_reg(CFG_NUM_POINTS, 16'hffff);
    write_reg(CFG_NUM_AVERAGE, 16'd1);
    write_reg(CFG_CIRCULAR_MODE, 16'd1);
    send_item(build_item(CMD_START, '0, '0, 1'b0, '0));
    repeat (3) send_item(build_item(CMD_SAMPLE, 3'd0, $urandom, 1'b1, '0));
    send_item(build_item(CMD_READ, 3'd0, '0, 1'b0, 11'd2047));
    send_item(build_item(CMD_READ, 3'd0, '0, 1'b0, 11'd2045));
    send_item(build_item(CMD_READ, 3'd0, '0, 1'b0, 11'd2044));
    send_item(build_item(CMD_READ, 3'd0, '0, 1'b0, 11'd0));
    send_item(build_item(CMD_READ, 3'd1, '0, 1'b0, 11'd2045));
    write_reg(CFG_CIRCULAR_MODE, 16'd0);
    send_item(build_item(CMD_START, '0, '0, 1'b0, '0));
    repeat (2) send_item(build_item(CMD_SAMPLE, 3'd0, $urandom, 1'b1, '0));
    for (int i = 0; i < 3; i++) send_item(build_item(CMD_READ, 3'd0, '0, 1'b0, 11'(i)));
    send_item(build_item(CMD_READ, 3'd0, '0, 1'b0, 11'd2047));
    send_item(build_item(CMD_STOP, '0, '0, 1'b0, '0));
  endtask

  task automatic test_random_traffic();
    int counted;
    int unsigned slot;
    int unsigned ns;
    int unsigned np;
    int unsigned lim;
    int unsigned r;
    logic eop;
    acb_in_t it;
    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle_en = (ph != 2);
      sink_idle_en = (ph != 2);
      write_reg(CFG_NUM_SIGNALS, {12'($urandom), 4'($urandom_range(15))});
      if ($urandom_range(9) < 8) write_reg(CFG_NUM_POINTS, {4'($urandom), 12'($urandom_range(12))});
      else write_reg(CFG_NUM_POINTS, 16'($urandom));
      write_reg(CFG_NUM_AVERAGE, 16'($urandom_range(3)));
      write_reg(CFG_CIRCULAR_MODE, {15'($urandom), 1'($urandom)});
      ns = used_channels();
      np = used_points();
      lim = (np + 1 > 2047) ? 2047 : np + 1;
      slot = 0;
      counted = 0;
      send_item(build_item(CMD_START, '0, '0, 1'b0, '0));
      while (counted < RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(99) < 3) wait_drained();
        r = $urandom_range(99);
        if (r < 4 || (r >= 20 && !capturing && $urandom_range(1) == 0)) begin
          it = build_item(CMD_START, 3'($urandom), $urandom, 1'($urandom), 11'($urandom));
          slot = 0;
        end else if (r < 7) begin
          it = build_item(CMD_STOP, 3'($urandom), $urandom, 1'($urandom), 11'($urandom));
        end else if (r < 20) begin
          it = build_item(CMD_READ, 3'($urandom), $urandom, 1'($urandom),
                          ($urandom_range(9) < 7) ? 11'($urandom_range(lim)) : 11'($urandom));
        end else if (r < 27) begin
          it = build_item(CMD_SAMPLE, 3'($urandom), pick_value(), 1'($urandom), 11'($urandom));
        end else begin
          eop = (slot >= ns - 1);
          it = build_item(CMD_SAMPLE, 3'(slot), pick_value(), eop, 11'($urandom));
          slot = eop ? 0 : slot + 1;
        end
        if (!(it.cmd == CMD_SAMPLE && !capturing)) counted++;
        send_item(it);
      end
    end
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin
    #200_000_000;
    $display("timeout: results still pending: %0d", expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    reset_predictor();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_idle_commands();
    test_register_clamps();
    test_quotient_saturation();
    test_deep_buffer();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("run covered %0d items and %0d results: %0d averaged points stored, %0d valid reads",
             items_sent, results_checked, points_predicted, valid_reads);
    $display("includes quotient saturation, clamped registers, %0d-point circular buffer",
             DEPTH);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
